FILE: sv/ems_pkg.sv
// Shared types, codes and a helper function of the ECU mode supervisor.
package ems_pkg;

    // Event codes carried in the kind field
    localparam logic [2:0] KIND_RELEASE    = 3'd0;
    localparam logic [2:0] KIND_INIT_FAIL  = 3'd1;
    localparam logic [2:0] KIND_DEADLINE   = 3'd2;
    localparam logic [2:0] KIND_RUN_ACT    = 3'd3;
    localparam logic [2:0] KIND_BOOT_CHECK = 3'd4;
    localparam logic [2:0] KIND_SAFE_HALT  = 3'd5;

    // Operating modes
    localparam logic [2:0] MODE_STARTUP   = 3'd0;
    localparam logic [2:0] MODE_RUN       = 3'd1;
    localparam logic [2:0] MODE_DEGRADED  = 3'd2;
    localparam logic [2:0] MODE_SHUTDOWN  = 3'd3;
    localparam logic [2:0] MODE_SAFE_HALT = 3'd4;

    // Reset causes that always re-arm the boot-loop window
    localparam logic [1:0] REASON_POWER_ON = 2'd0;
    localparam logic [1:0] REASON_BROWNOUT = 2'd1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_LOOP_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_US       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RESETS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADLINE_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_ACT_LIMIT   = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_INIT_LOOP_COUNT = 8'd0;
    localparam logic [31:0] RST_WINDOW_US       = 32'd60000000;
    localparam logic [7:0]  RST_MAX_RESETS      = 8'd3;
    localparam logic [7:0]  RST_DEADLINE_LIMIT  = 8'd5;
    localparam logic [15:0] RST_RUN_ACT_LIMIT   = 16'd240;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [63:0] time_us;
        logic [1:0]         reset_reason;
    } ems_in_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  mode;
        logic        gate_open;
        logic        reset_request;
        logic [7:0]  boot_loops_seen;
        logic [15:0] init_failure_count;
        logic [15:0] deadline_fault_count;
        logic [15:0] controlled_reset_count;
        logic [7:0]  retained_reset_count;
    } ems_out_t;

    // Saturating 16-bit increment
    function automatic logic [15:0] sat16_inc(input logic [15:0] v);
        logic [15:0] r;
        r = (v == 16'hFFFF) ? v : v + 16'd1;
        return r;
    endfunction

endpackage

FILE: sv/ems_in_stage.sv
// Input register of the ECU mode supervisor: holds one transaction for evaluation.
module ems_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ems_pkg::ems_in_t in_data,
    input  logic            advance,
    output logic            item_valid,
    output ems_pkg::ems_in_t item
);
    import ems_pkg::*;

    logic    valid_reg;
    ems_in_t data_reg;
    logic    take;

    // Stall only while a held transaction cannot move on
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

FILE: sv/ems_state_unit.sv
// Supervisor state, configuration registers and the per-event update logic.
module ems_state_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 upd,
    input  ems_pkg::ems_in_t                     item,
    input  logic                                 cfg_we,
    input  logic [ems_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ems_pkg::CFG_DATA_W-1:0]       cfg_data,
    output ems_pkg::ems_out_t                    res
);
    import ems_pkg::*;

    // Configuration
    logic [7:0]  init_loop_reg;
    logic [31:0] window_us_reg;
    logic [7:0]  max_resets_reg;
    logic [7:0]  dl_limit_reg;
    logic [15:0] run_limit_reg;

    // Supervisor state
    logic [2:0]  mode_reg,        mode_next;
    logic        gate_reg,        gate_next;
    logic [15:0] init_fail_reg,   init_fail_next;
    logic [15:0] deadline_reg,    deadline_next;
    logic        reset_req_reg,   reset_req_next;
    logic [15:0] ctrl_reset_reg,  ctrl_reset_next;
    logic [15:0] run_act_reg,     run_act_next;
    logic [7:0]  loop_count_reg,  loop_count_next;
    logic [7:0]  retained_reg,    retained_next;
    logic [63:0] win_start_reg,   win_start_next;
    logic        linked_reg,      linked_next;

    logic        acc;
    logic [15:0] dl_inc;
    logic [15:0] run_inc;
    logic        future;
    logic [63:0] elapsed;
    logic        rearm;
    logic [7:0]  rr;

    // Window arithmetic for boot-loop check
    assign future  = item.time_us < $signed(win_start_reg);
    assign elapsed = item.time_us - win_start_reg;
    assign rearm   = future || (elapsed > {32'd0, window_us_reg})
                     || (item.reset_reason == REASON_POWER_ON)
                     || (item.reset_reason == REASON_BROWNOUT);
    assign rr      = rearm ? 8'd0 : retained_reg;
    assign dl_inc  = sat16_inc(deadline_reg);
    assign run_inc = sat16_inc(run_act_reg);

    // Evaluate one event
    always_comb
    begin
        mode_next       = mode_reg;
        gate_next       = gate_reg;
        init_fail_next  = init_fail_reg;
        deadline_next   = deadline_reg;
        reset_req_next  = reset_req_reg;
        ctrl_reset_next = ctrl_reset_reg;
        run_act_next    = run_act_reg;
        loop_count_next = loop_count_reg;
        retained_next   = retained_reg;
        win_start_next  = win_start_reg;
        linked_next     = linked_reg;
        acc             = 1'b0;
        case (item.kind)
            KIND_RELEASE:
            begin
                if (!gate_reg)
                begin
                    gate_next = 1'b1;
                    mode_next = (init_fail_reg == 16'd0) ? MODE_RUN : MODE_DEGRADED;
                    acc       = 1'b1;
                end
            end
            KIND_INIT_FAIL:
            begin
                init_fail_next = sat16_inc(init_fail_reg);
                if (gate_reg)
                begin
                    mode_next = MODE_DEGRADED;
                end
            end
            KIND_DEADLINE:
            begin
                deadline_next = dl_inc;
                if (dl_inc >= {8'd0, dl_limit_reg})
                begin
                    mode_next       = MODE_SHUTDOWN;
                    reset_req_next  = 1'b1;
                    ctrl_reset_next = sat16_inc(ctrl_reset_reg);
                end
            end
            KIND_RUN_ACT:
            begin
                if (mode_reg == MODE_RUN)
                begin
                    run_act_next = run_inc;
                    if (run_inc >= run_limit_reg)
                    begin
                        if (linked_reg)
                        begin
                            retained_next = 8'd0;
                        end
                        run_act_next = 16'd0;
                    end
                end
            end
            KIND_BOOT_CHECK:
            begin
                if (rearm)
                begin
                    win_start_next = item.time_us;
                end
                if (rr >= max_resets_reg)
                begin
                    retained_next   = rr;
                    loop_count_next = rr;
                    mode_next       = MODE_SAFE_HALT;
                    reset_req_next  = 1'b0;
                    acc             = 1'b1;
                end
                else
                begin
                    retained_next   = (rr == 8'hFF) ? rr : rr + 8'd1;
                    loop_count_next = (rr == 8'hFF) ? rr : rr + 8'd1;
                    linked_next     = 1'b1;
                end
            end
            KIND_SAFE_HALT:
            begin
                mode_next      = MODE_SAFE_HALT;
                reset_req_next = 1'b0;
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
    end

    // Result reflects the state after this event
    always_comb
    begin
        res.accepted               = acc;
        res.mode                   = mode_next;
        res.gate_open              = gate_next;
        res.reset_request          = reset_req_next;
        res.boot_loops_seen        = loop_count_next;
        res.init_failure_count     = init_fail_next;
        res.deadline_fault_count   = deadline_next;
        res.controlled_reset_count = ctrl_reset_next;
        res.retained_reset_count   = retained_next;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_loop_reg  <= RST_INIT_LOOP_COUNT;
            window_us_reg  <= RST_WINDOW_US;
            max_resets_reg <= RST_MAX_RESETS;
            dl_limit_reg   <= RST_DEADLINE_LIMIT;
            run_limit_reg  <= RST_RUN_ACT_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INIT_LOOP_COUNT: init_loop_reg  <= cfg_data[7:0];
                CFG_WINDOW_US:       window_us_reg  <= cfg_data;
                CFG_MAX_RESETS:      max_resets_reg <= cfg_data[7:0];
                CFG_DEADLINE_LIMIT:  dl_limit_reg   <= cfg_data[7:0];
                CFG_RUN_ACT_LIMIT:   run_limit_reg  <= cfg_data[15:0];
                default:             init_loop_reg  <= init_loop_reg;
            endcase
        end
    end

    // Boot loop count: loaded by configuration, else updated by events
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_count_reg <= RST_INIT_LOOP_COUNT;
        end
        else if (cfg_we && (cfg_index == CFG_INIT_LOOP_COUNT))
        begin
            loop_count_reg <= cfg_data[7:0];
        end
        else if (upd)
        begin
            loop_count_reg <= loop_count_next;
        end
    end

    // Commit event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_STARTUP;
            gate_reg       <= 1'b0;
            init_fail_reg  <= 16'd0;
            deadline_reg   <= 16'd0;
            reset_req_reg  <= 1'b0;
            ctrl_reset_reg <= 16'd0;
            run_act_reg    <= 16'd0;
            retained_reg   <= 8'd0;
            win_start_reg  <= 64'd0;
            linked_reg     <= 1'b0;
        end
        else if (upd)
        begin
            mode_reg       <= mode_next;
            gate_reg       <= gate_next;
            init_fail_reg  <= init_fail_next;
            deadline_reg   <= deadline_next;
            reset_req_reg  <= reset_req_next;
            ctrl_reset_reg <= ctrl_reset_next;
            run_act_reg    <= run_act_next;
            retained_reg   <= retained_next;
            win_start_reg  <= win_start_next;
            linked_reg     <= linked_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Safe halt event always lands in safe halt with no reset request
    a_safe_halt: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && item.kind == KIND_SAFE_HALT) |=>
        (mode_reg == MODE_SAFE_HALT && !reset_req_reg))
        else $error("safe halt event did not halt");

    // Start gate never closes once released
    a_gate_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(gate_reg))
        else $error("start gate closed");

    // Init failure count never goes down
    a_init_mono: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (init_fail_reg >= $past(init_fail_reg)))
        else $error("init failure count decreased");

    // An accepted boot-loop check means safe halt
    a_boot_halt: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && item.kind == KIND_BOOT_CHECK && acc) |=> (mode_reg == MODE_SAFE_HALT))
        else $error("boot-loop limit did not halt");
`endif

endmodule

FILE: sv/ems_out_stage.sv
// Result register of the ECU mode supervisor and the pipeline advance control.
module ems_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  ems_pkg::ems_out_t res,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output ems_pkg::ems_out_t out_data
);
    import ems_pkg::*;

    logic     valid_reg;
    ems_out_t data_reg;

    // Move on when the result slot is empty or being taken
    assign advance = !valid_reg || !out_stall;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    // Capture result
    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/ecu_mode_supervisor_core.sv
// Top level of the ECU mode supervisor.
//
// Input channel: in_valid / in_stall / in_data carry one supervisory event per
// transaction (release, init failure, deadline fault, run activation,
// boot-loop check, safe halt). Output channel: out_valid / out_stall /
// out_data return exactly one result per event: the accepted flag and the
// mode, flags and counters as they stand after that event.
// A transaction moves on each rising edge where valid is high and stall low.
// The event is held in the input register; its result is then captured in the
// result register. Throughput: one event per cycle while out_stall is low; the
// combinational state update between the two registers sets this, with the
// 64-bit window subtract and compare as its longest path.
// Stalls: while out_stall holds a result, the input register keeps its event
// and in_stall rises once that register is full; nothing is dropped.
// Configuration: cfg_we / cfg_index / cfg_data write one register per edge; the
// user must write only while no event is in flight, which the block does not
// enforce. Writing the initial boot loop count also loads the boot loop count.
// Reset: rst_n clears both registers, the mode (startup), all counters and
// flags, and restores configuration defaults.
module ecu_mode_supervisor_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ems_pkg::ems_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ems_pkg::ems_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [ems_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ems_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ems_pkg::*;

    logic     advance;
    logic     item_valid;
    ems_in_t  item;
    ems_out_t res;

    ems_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ems_state_unit u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (item_valid && advance),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    ems_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res        (res),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the ECU mode supervisor core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ems_pkg::*;

    // Event kinds and reset causes that have no name in the package
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam logic [1:0] REASON_OTHER  = 2'd2;
    localparam logic [1:0] REASON_SPARE  = 2'd3;

    localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam int QUIET_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 8;

    typedef enum {MIX_ANY, MIX_LOOP_BUILDUP} event_mix_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    ems_in_t                in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    ems_out_t               out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_INIT_LOOP_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predicted configuration and supervisor state
    logic [31:0]        window_len      = RST_WINDOW_US;
    logic [7:0]         halt_threshold  = RST_MAX_RESETS;
    logic [7:0]         fault_threshold = RST_DEADLINE_LIMIT;
    logic [15:0]        clear_threshold = RST_RUN_ACT_LIMIT;
    logic [2:0]         mode_q          = MODE_STARTUP;
    logic               gate_q          = 1'b0;
    logic               reset_req_q     = 1'b0;
    logic               linked_q        = 1'b0;
    logic [15:0]        init_fail_q     = '0;
    logic [15:0]        deadline_q      = '0;
    logic [15:0]        ctrl_reset_q    = '0;
    logic [15:0]        run_act_q       = '0;
    logic [7:0]         loop_count_q    = RST_INIT_LOOP_COUNT;
    logic [7:0]         retained_q      = '0;
    logic signed [63:0] window_start_q  = '0;

    ems_in_t  pending_events[$];
    ems_out_t expected_results[$];

    int                 fault_count   = 0;
    int                 quiet_cycles  = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct     = 0;
    logic               in_took       = 1'b0;
    logic signed [63:0] stamp         = '0;

    ecu_mode_supervisor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Advance the predicted state by one event and return the expected result
    function automatic ems_out_t supervise(input ems_in_t ev);
        ems_out_t    res;
        logic [63:0] elapsed;
        logic        stale;
        res = '0;
        case (ev.kind)
            KIND_RELEASE:
            begin
                if (!gate_q)
                begin
                    gate_q = 1'b1;
                    mode_q = (init_fail_q == 16'd0) ? MODE_RUN : MODE_DEGRADED;
                    res.accepted = 1'b1;
                end
            end
            KIND_INIT_FAIL:
            begin
                init_fail_q = bump16(init_fail_q);
                if (gate_q)
                    mode_q = MODE_DEGRADED;
            end
            KIND_DEADLINE:
            begin
                deadline_q = bump16(deadline_q);
                if (deadline_q >= {8'd0, fault_threshold})
                begin
                    mode_q       = MODE_SHUTDOWN;
                    reset_req_q  = 1'b1;
                    ctrl_reset_q = bump16(ctrl_reset_q);
                end
            end
            KIND_RUN_ACT:
            begin
                if (mode_q == MODE_RUN)
                begin
                    run_act_q = bump16(run_act_q);
                    if (run_act_q >= clear_threshold)
                    begin
                        if (linked_q)
                            retained_q = '0;
                        run_act_q = '0;
                    end
                end
            end
            KIND_BOOT_CHECK:
            begin
                // exact difference; a window start in the future counts as expired
                elapsed = ev.time_us - window_start_q;
                stale = ($signed(ev.time_us) < $signed(window_start_q))
                        || (elapsed > {32'd0, window_len});
                if (ev.reset_reason == REASON_POWER_ON || ev.reset_reason == REASON_BROWNOUT
                    || stale)
                begin
                    retained_q     = '0;
                    window_start_q = ev.time_us;
                end
                if (retained_q >= halt_threshold)
                begin
                    loop_count_q = retained_q;
                    mode_q       = MODE_SAFE_HALT;
                    reset_req_q  = 1'b0;
                    res.accepted = 1'b1;
                end
                else
                begin
                    if (retained_q != 8'hFF)
                        retained_q = retained_q + 8'd1;
                    loop_count_q = retained_q;
                    linked_q     = 1'b1;
                end
            end
            KIND_SAFE_HALT:
            begin
                mode_q      = MODE_SAFE_HALT;
                reset_req_q = 1'b0;
            end
            default:
            begin
            end
        endcase
        res.mode                   = mode_q;
        res.gate_open              = gate_q;
        res.reset_request          = reset_req_q;
        res.boot_loops_seen        = loop_count_q;
        res.init_failure_count     = init_fail_q;
        res.deadline_fault_count   = deadline_q;
        res.controlled_reset_count = ctrl_reset_q;
        res.retained_reset_count   = retained_q;
        return res;
    endfunction

    function automatic string describe(input ems_out_t r);
        return $sformatf({"acc %0b mode %0d gate %0b rreq %0b loops %0d ",
                          "init %0d dl %0d crst %0d ret %0d"},
                         r.accepted, r.mode, r.gate_open, r.reset_request, r.boot_loops_seen,
                         r.init_failure_count, r.deadline_fault_count,
                         r.controlled_reset_count, r.retained_reset_count);
    endfunction

    // Move the running timestamp: mostly small steps, sometimes across the
    // window edge, backwards by up to 1000, or anywhere at all
    function automatic logic signed [63:0] next_stamp(input int unsigned calm_pct,
                                                      input int unsigned calm_step);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < calm_pct)
            stamp = stamp + $urandom_range(0, calm_step);
        else if (pick < calm_pct + 8)
            stamp = stamp + {32'd0, window_len} + $urandom_range(0, 1);
        else if (pick < calm_pct + 14)
            stamp = stamp - $urandom_range(1, 1000);
        else if (pick < calm_pct + 18)
            stamp = {$urandom, $urandom};
        else
            stamp = stamp + $urandom_range(0, 3);
        return stamp;
    endfunction

    function automatic ems_in_t random_event(input event_mix_t mix);
        ems_in_t     ev;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        ev.time_us      = {$urandom, $urandom};
        ev.reset_reason = 2'($urandom_range(REASON_POWER_ON, REASON_SPARE));
        if (mix == MIX_LOOP_BUILDUP)
        begin
            // long runs of checks inside one window drive the retained count to its limit
            if (pick < 92)
            begin
                ev.kind         = KIND_BOOT_CHECK;
                ev.reset_reason = pick[0] ? REASON_OTHER : REASON_SPARE;
                ev.time_us      = next_stamp(100, 1000);
            end
            else
            begin
                ev.kind = pick[0] ? KIND_RUN_ACT : KIND_DEADLINE;
            end
        end
        else
        begin
            ev.kind = (pick < 30) ? KIND_BOOT_CHECK
                                  : 3'($urandom_range(KIND_RELEASE, KIND_SPARE_HI));
            if (ev.kind == KIND_BOOT_CHECK)
                ev.time_us = next_stamp(60, window_len >> 2);
        end
        return ev;
    endfunction

    function automatic void push_event(input logic [2:0] kind, input logic signed [63:0] t,
                                       input logic [1:0] reason);
        ems_in_t ev;
        ev.kind         = kind;
        ev.time_us      = t;
        ev.reset_reason = reason;
        pending_events.push_back(ev);
    endfunction

    task automatic queue_random(input event_mix_t mix, input int count);
        repeat (count) pending_events.push_back(random_event(mix));
    endtask

    // Hold until every queued event is sent and every result has come back;
    // look halfway through the low phase, once the driver has settled
    task automatic wait_drained();
        @(negedge clk);
        #0.5;
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
            #0.5;
        end
    endtask

    task automatic put_setting(input logic [CFG_INDEX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
    endtask

    task automatic apply_settings(input logic [7:0] loops, input logic [31:0] window,
                                  input logic [7:0] halt_at, input logic [7:0] fault_at,
                                  input logic [15:0] clear_at);
        wait_drained();
        put_setting(CFG_INIT_LOOP_COUNT, {24'd0, loops});
        put_setting(CFG_WINDOW_US, window);
        put_setting(CFG_MAX_RESETS, {24'd0, halt_at});
        put_setting(CFG_DEADLINE_LIMIT, {24'd0, fault_at});
        put_setting(CFG_RUN_ACT_LIMIT, {16'd0, clear_at});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Present the next event once the previous transaction has gone through
    always @(negedge clk)
    begin : drive_events
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_events.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : drive_stall
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Check results, track register writes and predict accepted events
    always @(posedge clk)
    begin : check_results
        ems_out_t want;
        logic     out_took;
        if (rst_n)
        begin
            in_took  = in_valid && !in_stall;
            out_took = out_valid && !out_stall;
            // compare before queuing this edge's prediction so a stray result is caught
            if (out_took)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("unexpected result: %s", describe(out_data));
                    fault_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.accepted !== want.accepted
                        || out_data.mode !== want.mode
                        || out_data.gate_open !== want.gate_open
                        || out_data.reset_request !== want.reset_request
                        || out_data.boot_loops_seen !== want.boot_loops_seen
                        || out_data.init_failure_count !== want.init_failure_count
                        || out_data.deadline_fault_count !== want.deadline_fault_count
                        || out_data.controlled_reset_count !== want.controlled_reset_count
                        || out_data.retained_reset_count !== want.retained_reset_count)
                    begin
                        if (fault_count < REPORT_LIMIT)
                        begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(out_data));
                        end
                        fault_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INIT_LOOP_COUNT: loop_count_q    = cfg_data[7:0];
                    CFG_WINDOW_US:       window_len      = cfg_data;
                    CFG_MAX_RESETS:      halt_threshold  = cfg_data[7:0];
                    CFG_DEADLINE_LIMIT:  fault_threshold = cfg_data[7:0];
                    CFG_RUN_ACT_LIMIT:   clear_threshold = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_took)
                expected_results.push_back(supervise(in_data));
            quiet_cycles = (in_took || out_took) ? 0 : quiet_cycles + 1;
        end
    end

    // End the run when no transaction has moved for too long
    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("testbench failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: spare kinds, startup behavior, window edges, release twice, run clearing
        apply_settings(8'd255, 32'd100, 8'd255, 8'd255, 16'd3);
        push_event(KIND_SPARE_LO, 64'sd0, REASON_POWER_ON);
        push_event(KIND_SPARE_HI, TIME_MAX, REASON_SPARE);
        push_event(KIND_RUN_ACT, 64'sd0, REASON_OTHER);
        push_event(KIND_DEADLINE, 64'sd0, REASON_OTHER);
        push_event(KIND_BOOT_CHECK, -64'sd5, REASON_OTHER);
        push_event(KIND_BOOT_CHECK, 64'sd95, REASON_SPARE);
        push_event(KIND_BOOT_CHECK, 64'sd96, REASON_OTHER);
        push_event(KIND_BOOT_CHECK, 64'sd96, REASON_POWER_ON);
        push_event(KIND_BOOT_CHECK, 64'sd100, REASON_BROWNOUT);
        push_event(KIND_RELEASE, TIME_MIN, REASON_OTHER);
        push_event(KIND_RELEASE, TIME_MAX, REASON_OTHER);
        repeat (4) push_event(KIND_RUN_ACT, 64'sd0, REASON_OTHER);

        // Directed: zero run limit, extreme timestamps, then leave run mode
        apply_settings(8'd255, 32'd100, 8'd255, 8'd2, 16'd0);
        repeat (2) push_event(KIND_RUN_ACT, 64'sd0, REASON_OTHER);
        push_event(KIND_BOOT_CHECK, TIME_MAX, REASON_OTHER);
        push_event(KIND_BOOT_CHECK, TIME_MIN, REASON_OTHER);
        push_event(KIND_BOOT_CHECK, TIME_MIN, REASON_SPARE);
        push_event(KIND_INIT_FAIL, 64'sd0, REASON_OTHER);
        push_event(KIND_DEADLINE, 64'sd0, REASON_OTHER);
        push_event(KIND_SAFE_HALT, 64'sd0, REASON_OTHER);

        // Random with sender gaps, default-like limits
        apply_settings(8'd0, 32'd5000, 8'd3, 8'd255, 16'd240);
        send_idle_pct = 54;
        queue_random(MIX_ANY, 260);

        // Build the retained count up to its top under receiver stalls
        apply_settings(8'd17, 32'hFFFF_FFFF, 8'd255, 8'd200, 16'hFFFF);
        send_idle_pct = 0;
        stall_pct     = 54;
        queue_random(MIX_LOOP_BUILDUP, 320);

        // Zero limits and a window of 1, light gaps on both sides
        apply_settings(8'd0, 32'd1, 8'd0, 8'd0, 16'd0);
        send_idle_pct = 9;
        stall_pct     = 9;
        queue_random(MIX_ANY, 280);

        // Random settings, full rate, with a full drain in the middle
        apply_settings(8'($urandom_range(0, 255)), 32'($urandom_range(1, 100000)),
                       8'($urandom_range(1, 8)), 8'($urandom_range(1, 255)),
                       16'($urandom_range(1, 16)));
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_random(MIX_ANY, 150);
        wait_drained();
        queue_random(MIX_ANY, 150);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
